@@ rtl/sdmn_pkg.sv @@
// Shared constants, codes and controller/datapath structs for the signed magic-number unit.
package sdmn_pkg;

    // Default working width of the divisor
    localparam int DATA_WIDTH_DEF = 64;

    // Fixed field widths of the channels
    localparam int DIVISOR_W = 64;
    localparam int MAGIC_W   = 64;
    localparam int SHIFT_W   = 6;

    // Operand selection for the shared divider
    localparam logic [1:0] SEL_T_AD     = 2'd0;  // (2^(W-1) + sign) mod |d|
    localparam logic [1:0] SEL_HALF_ANC = 2'd1;  // 2^(W-1) / anc
    localparam logic [1:0] SEL_HALF_AD  = 2'd2;  // 2^(W-1) / |d|

    // Controller to datapath commands
    typedef struct packed {
        logic       load;       // capture divisor on input transfer
        logic       div_start;  // launch a division
        logic [1:0] div_sel;    // operands of the launched division
        logic       take_a;     // capture anc from the first division
        logic       take_b;     // capture q1/r1
        logic       take_c;     // capture q2/r2, clear round count
        logic       step;       // one doubling round
        logic       out_load;   // write the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ad_small;   // |d| < 2
        logic div_done;   // divider finished, result valid this cycle
        logic loop_done;  // precision test passed or round cap reached
        logic out_full;   // result register cannot take a new result
    } t_status;

endpackage

@@ rtl/sdmn_if.sv @@
// Valid/ready channel interfaces for divisor input and magic-number result.
interface sdmn_in_if
    import sdmn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [DIVISOR_W-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

interface sdmn_out_if
    import sdmn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MAGIC_W-1:0] magic_multiplier;
    logic [SHIFT_W-1:0] extra_shift;
    logic               add_back;
    logic               invalid;

    modport source (output valid, output magic_multiplier, output extra_shift,
                    output add_back, output invalid, input ready);
    modport sink   (input valid, input magic_multiplier, input extra_shift,
                    input add_back, input invalid, output ready);
endinterface

@@ rtl/signed_div_magic_number_unit.sv @@
// Top level of the signed division magic-number unit.
// Usage:
//   i_in  (sink):   one signed divisor per transfer; only the low DATA_WIDTH bits
//                   are used, read as two's complement.
//   o_out (source): one result per divisor: magic multiplier (sign-extended from
//                   bit DATA_WIDTH-1), extra arithmetic shift, add-back flag and
//                   an invalid flag for divisors 0, 1 and -1 (other fields zero).
// Timing:
//   One divisor is worked on at a time; i_in.ready is high only when idle.
//   A valid divisor passes three restoring divisions on one shared divider,
//   then one doubling round per cycle until the precision test passes or
//   the round cap is reached, and then the result is written. An invalid
//   divisor skips the divisions and goes straight to the result write.
//   The next divisor can be taken the cycle after the result is written.
// Stall: the result sits in an output register; the next divisor is taken and
//   worked on while it waits, and only the final write waits for a free slot.
// Reset: i_rst_n is synchronous and active low; it returns the controller to
//   idle and empties the output register. No clearing pass is needed.
module signed_div_magic_number_unit
    import sdmn_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdmn_in_if.sink     i_in,
    sdmn_out_if.source  o_out
);

    t_cmd    cmd;
    t_status status;

    sdmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdmn_dp #(.W(DATA_WIDTH)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_divisor          (i_in.divisor),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_magic_multiplier (o_out.magic_multiplier),
        .o_extra_shift      (o_out.extra_shift),
        .o_add_back         (o_out.add_back),
        .o_invalid          (o_out.invalid)
    );

endmodule

@@ rtl/sdmn_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module sdmn_div
    import sdmn_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_rem, n_rem;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             ge;

    // Trial subtraction of the shifted partial remainder
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = (trial >= {1'b0, i_divisor});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[W-2:0], ge};
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/sdmn_dp.sv @@
// Datapath: operand registers, shared divider, doubling rounds and result register.
module sdmn_dp
    import sdmn_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [DIVISOR_W-1:0] i_divisor,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [MAGIC_W-1:0]   o_magic_multiplier,
    output logic [SHIFT_W-1:0]   o_extra_shift,
    output logic                 o_add_back,
    output logic                 o_invalid
);

    localparam int         CW   = $clog2(W + 1);
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  v;
    logic [W-1:0]  r_ad;
    logic          r_neg;
    logic [W-1:0]  t_val;
    logic [W-1:0]  r_anc;
    logic [W-1:0]  anc_raw;
    logic [W-1:0]  r_q1, r_r1, r_q2, r_r2;
    logic [CW-1:0] r_rounds;
    logic          r_out_valid;
    logic [MAGIC_W-1:0] r_magic;
    logic [SHIFT_W-1:0] r_shift;
    logic          r_add_back;
    logic          r_invalid;

    logic [W-1:0]  div_dividend, div_divisor;
    logic          div_done;
    logic [W-1:0]  div_quo, div_rem;

    logic [W:0]    r1_sh, r2_sh;
    logic          ge1, ge2;
    logic [W:0]    r1_diff, r2_diff;
    logic [W-1:0]  delta;
    logic          refine;
    logic [W-1:0]  m_val;
    logic [6:0]    shift7;
    logic          ad_lt_two;

    // Absolute divisor from the low W bits
    assign v         = i_divisor[W-1:0];
    assign t_val     = HALF + W'(r_neg);
    assign ad_lt_two = (r_ad < W'(2));

    // Divider operand selection
    always_comb begin
        case (i_cmd.div_sel)
            SEL_T_AD: begin
                div_dividend = t_val;
                div_divisor  = r_ad;
            end
            SEL_HALF_ANC: begin
                div_dividend = HALF;
                div_divisor  = r_anc;
            end
            SEL_HALF_AD: begin
                div_dividend = HALF;
                div_divisor  = r_ad;
            end
            default: begin
                div_dividend = HALF;
                div_divisor  = r_ad;
            end
        endcase
    end

    sdmn_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // anc = t - 1 - (t mod |d|), never zero
    assign anc_raw = t_val - W'(1) - div_rem;

    // One doubling round of both quotient/remainder pairs
    assign r1_sh   = {r_r1, 1'b0};
    assign r2_sh   = {r_r2, 1'b0};
    assign ge1     = (r1_sh >= {1'b0, r_anc});
    assign ge2     = (r2_sh >= {1'b0, r_ad});
    assign r1_diff = r1_sh - {1'b0, r_anc};
    assign r2_diff = r2_sh - {1'b0, r_ad};

    // Precision test on the registered pairs
    assign delta  = r_ad - r_r2;
    assign refine = ((r_q1 < delta) || ((r_q1 == delta) && (r_r1 == '0)))
                    && (r_rounds < CW'(W));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= v[W-1];
            r_ad  <= v[W-1] ? (W'(0) - v) : v;
        end
        if (i_cmd.take_a) begin
            r_anc <= (anc_raw == '0) ? W'(1) : anc_raw;
        end
        if (i_cmd.take_b) begin
            r_q1 <= div_quo;
            r_r1 <= div_rem;
        end
        if (i_cmd.take_c) begin
            r_q2     <= div_quo;
            r_r2     <= div_rem;
            r_rounds <= '0;
        end else if (i_cmd.step) begin
            r_q1     <= {r_q1[W-2:0], ge1};
            r_r1     <= ge1 ? r1_diff[W-1:0] : r1_sh[W-1:0];
            r_q2     <= {r_q2[W-2:0], ge2};
            r_r2     <= ge2 ? r2_diff[W-1:0] : r2_sh[W-1:0];
            r_rounds <= r_rounds + 1'b1;
        end
    end

    // Final magic number and shift
    assign m_val  = r_q2 + W'(1);
    assign shift7 = 7'(r_rounds) - 7'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_invalid  <= ad_lt_two;
            r_magic    <= ad_lt_two ? '0 : MAGIC_W'($signed(m_val));
            r_shift    <= ad_lt_two ? '0 : shift7[SHIFT_W-1:0];
            r_add_back <= ad_lt_two ? 1'b0 : m_val[W-1];
        end
    end

    // Result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.ad_small  = ad_lt_two;
    assign o_status.div_done  = div_done;
    assign o_status.loop_done = (r_rounds != '0) && !refine;
    assign o_status.out_full  = r_out_valid && !i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_magic_multiplier = r_magic;
    assign o_extra_shift      = r_shift;
    assign o_add_back         = r_add_back;
    assign o_invalid          = r_invalid;

endmodule

@@ rtl/sdmn_ctrl.sv @@
// Controller: sequences set-up, three divisions, doubling rounds and result write.
module sdmn_ctrl
    import sdmn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIVA  = 3'd2;
    localparam logic [2:0] S_STB   = 3'd3;
    localparam logic [2:0] S_DIVB  = 3'd4;
    localparam logic [2:0] S_DIVC  = 3'd5;
    localparam logic [2:0] S_LOOP  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_status.ad_small) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_T_AD;
                    n_state         = S_DIVA;
                end
            end
            S_DIVA: begin
                o_cmd.div_sel = SEL_T_AD;
                if (i_status.div_done) begin
                    o_cmd.take_a = 1'b1;
                    n_state      = S_STB;
                end
            end
            S_STB: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = SEL_HALF_ANC;
                n_state         = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.div_sel = SEL_HALF_ANC;
                if (i_status.div_done) begin
                    // second division ends, third starts on |d|
                    o_cmd.take_b    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = SEL_HALF_AD;
                    n_state         = S_DIVC;
                end
            end
            S_DIVC: begin
                o_cmd.div_sel = SEL_HALF_AD;
                if (i_status.div_done) begin
                    o_cmd.take_c = 1'b1;
                    n_state      = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_status.loop_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/sdmn_checker.sv @@
// Port-level checks for the magic-number unit, bound to the top level.
module sdmn_checker
    import sdmn_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [MAGIC_W-1:0] i_magic,
    input logic [SHIFT_W-1:0] i_shift,
    input logic               i_add_back,
    input logic               i_invalid
);

    // Reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One divisor at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while busy");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_magic)
            && $stable(i_shift) && $stable(i_add_back) && $stable(i_invalid)))
        else $error("stalled result changed");

    // Invalid divisors give zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_invalid) |-> (i_magic == '0 && i_shift == '0 && !i_add_back))
        else $error("invalid result with non-zero fields");

    // Add-back matches the sign of the magic number
    a_add_back_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_invalid) |-> (i_add_back == i_magic[MAGIC_W-1]))
        else $error("add-back disagrees with magic sign");

endmodule

bind signed_div_magic_number_unit sdmn_checker u_sdmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_magic     (o_out.magic_multiplier),
    .i_shift     (o_out.extra_shift),
    .i_add_back  (o_out.add_back),
    .i_invalid   (o_out.invalid)
);
